// File: rtl/stip_pkg.sv
// Shared types and constants for the string-to-integer parser.
// Holds the classified character record, the parse phase enum and character codes.
// No dependencies.
package stip_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;

    localparam logic [5:0] RADIX_AUTO = 6'd0;
    localparam logic [5:0] RADIX_ONE  = 6'd1;
    localparam logic [5:0] RADIX_OCT  = 6'd8;
    localparam logic [5:0] RADIX_DEC  = 6'd10;
    localparam logic [5:0] RADIX_HEX  = 6'd16;
    localparam logic [5:0] RADIX_MAX  = 6'd36;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // One character after classification.
    typedef struct packed {
        logic       start;
        logic [5:0] radix;
        logic       is_space;
        logic       is_sign;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic       dig_ok;
        logic [5:0] digit;
    } item_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WS,
        PH_SIGN,
        PH_ZERO,
        PH_XSEEN,
        PH_DIGITS
    } phase_t;

endpackage

// File: rtl/stip_front.sv
// Front end of the parser: classifies one character into an item_t record.
// Depends on stip_pkg.
module stip_front (
    input  logic            start_req,
    input  logic [7:0]      ch,
    input  logic [5:0]      radix,
    output stip_pkg::item_t item
);
    import stip_pkg::*;

    always_comb
    begin
        item.start    = start_req;
        item.radix    = radix;
        item.is_space = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL) ||
                        (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
        item.is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
        item.is_minus = (ch == CH_MINUS);
        item.is_zero  = (ch == CH_ZERO);
        item.is_x     = (ch == CH_LC_X) || (ch == CH_UC_X);
        item.dig_ok   = 1'b1;
        item.digit    = '0;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            item.digit = 6'(ch - CH_ZERO);
        end
        else if (ch >= CH_LC_A && ch <= CH_LC_Z)
        begin
            item.digit = 6'(ch - CH_LC_A + 8'd10);
        end
        else if (ch >= CH_UC_A && ch <= CH_UC_Z)
        begin
            item.digit = 6'(ch - CH_UC_A + 8'd10);
        end
        else
        begin
            item.dig_ok = 1'b0;
        end
    end

endmodule

// File: rtl/stip_fifo.sv
// Short queue of classified characters between front and back ends.
// Depends on stip_pkg for the item_t record.
module stip_fifo #(
    parameter int DEPTH = stip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  stip_pkg::item_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output stip_pkg::item_t rd_data,
    output logic            empty
);
    import stip_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    item_t           mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/stip_back.sv
// Back end of the parser: phase machine, multiply-add accumulator and result register.
// Depends on stip_pkg.
module stip_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  stip_pkg::item_t    item,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic signed [63:0] value,
    output logic [15:0]        consumed
);
    import stip_pkg::*;

    phase_t       phase_reg, phase_next;
    logic         neg_reg, neg_next;
    logic [5:0]   rad_reg, rad_next;
    logic [63:0]  acc_reg, acc_next;
    logic [15:0]  cnt_reg, cnt_next;
    logic         res_valid_reg, res_valid_next;
    logic [63:0]  res_value_reg, res_value_next;
    logic [15:0]  res_count_reg, res_count_next;
    logic         emit;
    logic         done;

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        sat_inc = (c == COUNT_MAX) ? c : c + 16'd1;
    endfunction

    // Advance only when a result slot is free or is being drained.
    assign q_pop = !q_empty && (!res_valid_reg || pop);

    always_comb
    begin
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        rad_next       = rad_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        emit           = 1'b0;
        done           = 1'b0;
        res_value_next = res_value_reg;
        res_count_next = res_count_reg;

        if (item.start)
        begin
            neg_next = 1'b0;
            acc_next = '0;
            cnt_next = '0;
            rad_next = item.radix;
            if (item.radix == RADIX_ONE || item.radix > RADIX_MAX)
            begin
                rad_next       = RADIX_AUTO;
                emit           = 1'b1;
                res_value_next = '0;
                res_count_next = '0;
                phase_next     = PH_IDLE;
                done           = 1'b1;
            end
            else
            begin
                phase_next = PH_WS;
            end
        end

        if (!done && phase_next == PH_IDLE)
        begin
            done = 1'b1;
        end

        if (!done && phase_next == PH_WS)
        begin
            if (item.is_space)
            begin
                cnt_next = sat_inc(cnt_next);
                done     = 1'b1;
            end
            else if (item.is_sign)
            begin
                neg_next   = item.is_minus;
                cnt_next   = sat_inc(cnt_next);
                phase_next = PH_SIGN;
                done       = 1'b1;
            end
            else
            begin
                phase_next = PH_SIGN;
            end
        end

        if (!done && phase_next == PH_SIGN)
        begin
            if (item.is_zero && (rad_next == RADIX_AUTO || rad_next == RADIX_HEX))
            begin
                cnt_next   = sat_inc(cnt_next);
                acc_next   = '0;
                phase_next = PH_ZERO;
                done       = 1'b1;
            end
            else
            begin
                if (rad_next == RADIX_AUTO)
                begin
                    rad_next = RADIX_DEC;
                end
                if (item.dig_ok && item.digit < rad_next)
                begin
                    acc_next   = 64'(item.digit);
                    cnt_next   = sat_inc(cnt_next);
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    // no digit at all: report zero and nothing consumed
                    emit           = 1'b1;
                    res_value_next = '0;
                    res_count_next = '0;
                    phase_next     = PH_IDLE;
                end
                done = 1'b1;
            end
        end

        if (!done && phase_next == PH_ZERO)
        begin
            if (item.is_x)
            begin
                rad_next   = RADIX_HEX;
                phase_next = PH_XSEEN;
                done       = 1'b1;
            end
            else
            begin
                if (rad_next == RADIX_AUTO)
                begin
                    rad_next = RADIX_OCT;
                end
                phase_next = PH_DIGITS;
            end
        end

        if (!done && phase_next == PH_XSEEN)
        begin
            if (item.dig_ok && item.digit < RADIX_HEX)
            begin
                acc_next   = 64'(item.digit);
                cnt_next   = sat_inc(sat_inc(cnt_next));
                phase_next = PH_DIGITS;
            end
            else
            begin
                // prefix with no hex digit: the x is not counted, only what came before it
                emit           = 1'b1;
                res_value_next = '0;
                res_count_next = cnt_next;
                phase_next     = PH_IDLE;
            end
            done = 1'b1;
        end

        if (!done && phase_next == PH_DIGITS)
        begin
            if (item.dig_ok && item.digit < rad_next)
            begin
                acc_next = acc_next * 64'(rad_next) + 64'(item.digit);
                cnt_next = sat_inc(cnt_next);
            end
            else
            begin
                emit           = 1'b1;
                res_value_next = neg_next ? (64'd0 - acc_next) : acc_next;
                res_count_next = cnt_next;
                phase_next     = PH_IDLE;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
        if (q_pop && emit)
        begin
            res_valid_next = 1'b1;
        end
        empty    = !res_valid_reg;
        value    = res_value_reg;
        consumed = res_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            neg_reg       <= 1'b0;
            rad_reg       <= RADIX_AUTO;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (q_pop)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                rad_reg   <= rad_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            res_value_reg <= res_value_next;
            res_count_reg <= res_count_next;
        end
    end

endmodule

// File: rtl/string_to_integer_parser.sv
// Streaming strtol-style parser: one character per transaction, at most one result per string.
// A terminator is written into the character queue, then popped by the back end into the result register (empty low).
// Throughput: one character per cycle while full is low and the back end's result register is free or being popped.
// A full result register holds the back end; the character queue keeps push open until it fills.
// Reset (rst_n low, asynchronous): queue empty, no result pending, parser idle.
// Depends on stip_pkg, stip_front, stip_fifo and stip_back.
module string_to_integer_parser #(
    parameter int QUEUE_DEPTH = stip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               start_req,
    input  logic [7:0]         ch,
    input  logic [5:0]         radix,
    output logic               empty,
    input  logic               pop,
    output logic signed [63:0] value,
    output logic [15:0]        consumed
);
    import stip_pkg::*;

    item_t front_item;
    item_t q_item;
    logic  q_empty;
    logic  q_pop;
    logic  q_push;

    // Classify the incoming character; no state lives in the front end.
    stip_front u_front (
        .start_req (start_req),
        .ch        (ch),
        .radix     (radix),
        .item      (front_item)
    );

    // A transaction on the input side lands straight in the queue.
    assign q_push = push && !full;

    // Decouple the two halves so a stalled result does not block input until the queue fills.
    stip_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (front_item),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_item),
        .empty   (q_empty)
    );

    // Run the phase machine and accumulate; drop characters while idle.
    stip_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .item     (q_item),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .value    (value),
        .consumed (consumed)
    );

endmodule

// File: test/string_to_integer_parser_tb.sv
// Self-checking testbench for string_to_integer_parser: streams characters in, checks each
// converted value and consumed count against an in-bench strtol-style parse model.
// Depends on stip_pkg and string_to_integer_parser from the rtl folder.
module string_to_integer_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import stip_pkg::*;

    localparam int NOT_A_DIGIT  = 99;
    localparam int SETTLE_TICKS = 12;          // settling margin after the last expected result is checked
    localparam int MAX_REPORTS  = 40;
    localparam int LONG_HOLD    = 400;
    localparam int SAT_BLANKS   = 65600;       // enough whitespace to pin the count at max
    localparam int RANDOM_CHARS = 2000;

    typedef logic [7:0] byte_q_t[$];

    // One expected conversion: what the block must report for a terminated string.
    typedef struct {
        logic signed [63:0] value;
        logic [15:0]        consumed;
    } conversion_t;

    logic clk = 1'b0;
    logic rst_n;
    logic push;
    logic full;
    logic start_req;
    logic [7:0] ch;
    logic [5:0] radix;
    logic empty;
    logic pop;
    logic signed [63:0] value;
    logic [15:0] consumed;

    // Parse model state, mirrors what the block keeps between characters.
    phase_t      parse_phase;
    logic        parse_negative;
    logic [5:0]  parse_radix;
    logic [63:0] parse_acc;
    logic [15:0] parse_count;

    conversion_t expected_conversions[$];

    int  error_count = 0;
    int  chars_sent = 0;
    int  conversions_checked = 0;
    bit  send_idle_on = 1'b0;
    bit  recv_idle_on = 1'b0;
    int  hold_cycles = 0;
    int  pop_idle_left = 0;

    string_to_integer_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .start_req (start_req),
        .ch        (ch),
        .radix     (radix),
        .empty     (empty),
        .pop       (pop),
        .value     (value),
        .consumed  (consumed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parse model
    // ------------------------------------------------------------------

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR ||
               c == CH_FF || c == CH_VT;
    endfunction

    // Map a character to its digit value across bases up to 36.
    function automatic int digit_value(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c) - int'(CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_Z)
            return int'(c) - int'(CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_Z)
            return int'(c) - int'(CH_UC_A) + 10;
        return NOT_A_DIGIT;
    endfunction

    function automatic void bump_count();
        if (parse_count != COUNT_MAX)
            parse_count++;
    endfunction

    function automatic void post_result(logic [63:0] v, logic [15:0] n);
        conversion_t item;
        item.value = v;
        item.consumed = n;
        expected_conversions.push_back(item);
        parse_phase = PH_IDLE;
    endfunction

    function automatic void clear_parse_state();
        parse_phase = PH_IDLE;
        parse_negative = 1'b0;
        parse_radix = RADIX_AUTO;
        parse_acc = '0;
        parse_count = '0;
    endfunction

    // Advance the parse model by one accepted character; queue a result on a terminator.
    // The phases fall through into one another within a single character, as in hardware.
    function automatic void convert_char(logic st, logic [7:0] c, logic [5:0] r);
        int d;
        if (st)
        begin
            parse_negative = 1'b0;
            parse_acc = '0;
            parse_count = '0;
            parse_radix = r;
            if (r == RADIX_ONE || r > RADIX_MAX)
            begin
                parse_radix = RADIX_AUTO;
                post_result('0, '0);
                return;
            end
            parse_phase = PH_WS;
        end

        if (parse_phase == PH_IDLE)
            return;

        if (parse_phase == PH_WS)
        begin
            if (is_blank(c))
            begin
                bump_count();
                return;
            end
            if (c == CH_MINUS || c == CH_PLUS)
            begin
                parse_negative = (c == CH_MINUS);
                bump_count();
                parse_phase = PH_SIGN;
                return;
            end
            parse_phase = PH_SIGN;
        end

        if (parse_phase == PH_SIGN)
        begin
            if (c == CH_ZERO && (parse_radix == RADIX_AUTO || parse_radix == RADIX_HEX))
            begin
                bump_count();
                parse_acc = '0;
                parse_phase = PH_ZERO;
                return;
            end
            if (parse_radix == RADIX_AUTO)
                parse_radix = RADIX_DEC;
            d = digit_value(c);
            if (d < int'(parse_radix))
            begin
                parse_acc = 64'(d);
                bump_count();
                parse_phase = PH_DIGITS;
                return;
            end
            post_result('0, '0);
            return;
        end

        if (parse_phase == PH_ZERO)
        begin
            if (c == CH_LC_X || c == CH_UC_X)
            begin
                parse_radix = RADIX_HEX;
                parse_phase = PH_XSEEN;
                return;
            end
            if (parse_radix == RADIX_AUTO)
                parse_radix = RADIX_OCT;
            parse_phase = PH_DIGITS;
        end

        if (parse_phase == PH_XSEEN)
        begin
            d = digit_value(c);
            // The x only counts once a hex digit confirms the prefix.
            if (d < 16)
            begin
                parse_acc = 64'(d);
                bump_count();
                bump_count();
                parse_phase = PH_DIGITS;
                return;
            end
            post_result('0, parse_count);
            return;
        end

        if (parse_phase == PH_DIGITS)
        begin
            d = digit_value(c);
            if (d < int'(parse_radix))
            begin
                parse_acc = parse_acc * 64'(parse_radix) + 64'(d);
                bump_count();
                return;
            end
            post_result(parse_negative ? 64'd0 - parse_acc : parse_acc, parse_count);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one character; hold it until a rising edge sees full low. Return at that edge,
    // so push is still high and the next call can keep it high without a gap.
    task automatic send_char(input logic st, input logic [7:0] c, input logic [5:0] r);
        int gap;
        gap = 0;
        if (send_idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push <= 1'b1;
        start_req <= st;
        ch <= c;
        radix <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        chars_sent++;
        convert_char(st, c, r);
    endtask

    // Send a string: the first character carries start and the base; later characters
    // carry junk in the radix field, which the block must ignore.
    task automatic send_bytes(input byte_q_t text, input logic [5:0] r);
        foreach (text[i])
        begin
            if (i == 0)
                send_char(1'b1, text[i], r);
            else
                send_char(1'b0, text[i], 6'($urandom_range(0, 63)));
        end
    endtask

    task automatic send_text(input string s, input logic [5:0] r);
        byte_q_t text;
        text = {};
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_bytes(text, r);
    endtask

    // Drop push, then wait until every expected conversion has been popped and checked.
    task automatic wait_for_results();
        @(negedge clk);
        push <= 1'b0;
        while (expected_conversions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Drive pop at the falling edge. A long hold requested by a test is counted down here;
    // otherwise insert short random idle bursts while receiver idling is enabled.
    initial
    begin : pop_driver
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                pop <= 1'b0;
                hold_cycles--;
            end
            else if (pop_idle_left > 0)
            begin
                pop <= 1'b0;
                pop_idle_left--;
            end
            else if (recv_idle_on && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                pop_idle_left = $urandom_range(0, 14);
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Check each popped transaction against the oldest expected conversion.
    always @(posedge clk)
    begin : result_checker
        conversion_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_conversions.size() == 0)
                report_mismatch($sformatf("unexpected result value=%0d consumed=%0d",
                                          value, consumed));
            else
            begin
                want = expected_conversions.pop_front();
                conversions_checked++;
                if (value !== want.value)
                    report_mismatch($sformatf("value %0d, expected %0d", value, want.value));
                if (consumed !== want.consumed)
                    report_mismatch($sformatf("consumed %0d, expected %0d",
                                              consumed, want.consumed));
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Leading whitespace of every kind, both signs, a lone sign, whitespace with no digit and a doubled sign.
    task automatic test_space_and_sign();
        byte_q_t text;
        text = {CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR, CH_SPACE, CH_MINUS, "4", "2", ";"};
        send_bytes(text, RADIX_DEC);
        send_text("+17 ", RADIX_AUTO);
        send_text("  -;", RADIX_AUTO);
        send_text("   q", RADIX_DEC);
        send_text("-+5", RADIX_DEC);
    endtask

    // Auto base: hex after 0x/0X, octal after 0, decimal otherwise; 0x with no hex digit; 0x under set bases.
    task automatic test_auto_base();
        send_text("+0x1F,", RADIX_AUTO);
        send_text("-0Xab!", RADIX_AUTO);
        send_text("0758", RADIX_AUTO);
        send_text("0 ", RADIX_AUTO);
        send_text("0xg", RADIX_AUTO);
        send_text("0x", RADIX_HEX);
        send_text(".", RADIX_HEX);
        send_text("0x8", RADIX_OCT);
        send_text("905a", RADIX_AUTO);
    endtask

    // Smallest and largest bases, letter digits in both cases, high-bit terminator.
    task automatic test_base_range();
        byte_q_t text;
        send_text("1012", 6'd2);
        send_text("Zz ", RADIX_MAX);
        send_text("0x7fffFFFFffffffff!", RADIX_HEX);
        text = {"7", "f", 8'hFF};
        send_bytes(text, RADIX_HEX);
        text = {"1", "2", 8'h80};
        send_bytes(text, 6'd3);
    endtask

    // Wraparound of the accumulator and negation modulo 2^64.
    task automatic test_wraparound();
        send_text("-9223372036854775808.", RADIX_DEC);
        send_text("18446744073709551616;", RADIX_DEC);
        send_text("999999999999999999999999999999 ", RADIX_DEC);
        send_text("ffffffffffffffff ", RADIX_HEX);
        send_text("-0x8000000000000000;", RADIX_AUTO);
        send_text("-1;", RADIX_AUTO);
    endtask

    // Invalid bases report at once; stray characters while idle are ignored; a new start
    // abandons a conversion in progress, including one caught inside the hex prefix.
    task automatic test_bad_radix_and_restart();
        send_char(1'b1, "7", RADIX_ONE);
        send_char(1'b0, "7", RADIX_DEC);
        send_char(1'b1, "5", 6'd37);
        send_char(1'b1, "5", 6'd63);
        send_char(1'b0, ";", RADIX_AUTO);
        send_text("123", RADIX_DEC);
        send_text("9;", RADIX_DEC);
        send_text("0x", RADIX_AUTO);
        send_text("-8 ", RADIX_AUTO);
    endtask

    // Run a whitespace prefix past the counter's range so consumed saturates.
    task automatic test_count_saturation();
        bit saved;
        saved = send_idle_on;
        send_idle_on = 1'b0;
        send_char(1'b1, CH_SPACE, RADIX_DEC);
        repeat (SAT_BLANKS) send_char(1'b0, CH_SPACE, 6'($urandom_range(0, 63)));
        send_char(1'b0, "1", RADIX_DEC);
        send_char(1'b0, "2", RADIX_DEC);
        send_char(1'b0, ";", RADIX_DEC);
        send_idle_on = saved;
        wait_for_results();
    endtask

    // Hold off the receiver for a long stretch while short strings keep coming, so the
    // result register and character queue fill and full stalls the sender; then pause
    // the sender until everything has drained.
    task automatic test_backpressure();
        bit saved;
        wait_for_results();
        saved = send_idle_on;
        send_idle_on = 1'b0;
        hold_cycles = LONG_HOLD;
        repeat (30) send_text("5,", RADIX_DEC);
        send_idle_on = saved;
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Random strings
    // ------------------------------------------------------------------

    function automatic logic [7:0] blank_char(int k);
        case (k)
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_NL;
            3:       return CH_CR;
            4:       return CH_FF;
            default: return CH_VT;
        endcase
    endfunction

    function automatic logic [7:0] digit_char(int v);
        if (v < 10)
            return CH_ZERO + 8'(v);
        if ($urandom_range(0, 1) != 0)
            return CH_LC_A + 8'(v - 10);
        return CH_UC_A + 8'(v - 10);
    endfunction

    // Mostly well-formed numbers with random content, with some noise: stray bytes,
    // random restarts, bad bases and missing terminators. Drop idling in the last tenth.
    task automatic test_random_strings();
        byte_q_t    text;
        logic [5:0] r;
        int         base_of_digits;
        int         sel;
        int         n;
        int         stop_at;
        stop_at = chars_sent + RANDOM_CHARS;
        while (chars_sent < stop_at)
        begin
            if (chars_sent >= stop_at - RANDOM_CHARS / 10)
            begin
                send_idle_on = 1'b0;
                recv_idle_on = 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_char($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)),
                              6'($urandom_range(0, 63)));
            end
            else
            begin
                text = {};
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    r = ($urandom_range(0, 1) != 0) ? RADIX_ONE : 6'($urandom_range(37, 63));
                else if (sel < 7)
                    r = RADIX_AUTO;
                else if (sel < 10)
                    r = RADIX_HEX;
                else if (sel < 12)
                    r = RADIX_DEC;
                else if (sel < 14)
                    r = RADIX_OCT;
                else if (sel == 14)
                    r = 6'd2;
                else if (sel == 15)
                    r = RADIX_MAX;
                else
                    r = 6'($urandom_range(2, 36));

                if (r == RADIX_AUTO || r == RADIX_ONE || r > RADIX_MAX)
                    base_of_digits = 10;
                else
                    base_of_digits = int'(r);

                repeat ($urandom_range(0, 3))
                    text.push_back(blank_char($urandom_range(0, 5)));

                sel = $urandom_range(0, 3);
                if (sel == 1)
                    text.push_back(CH_PLUS);
                else if (sel == 2)
                    text.push_back(CH_MINUS);

                if (r == RADIX_AUTO || r == RADIX_HEX)
                begin
                    sel = $urandom_range(0, 3);
                    if (sel == 1)
                    begin
                        text.push_back(CH_ZERO);
                        if (r == RADIX_AUTO)
                            base_of_digits = 8;
                    end
                    else if (sel >= 2)
                    begin
                        text.push_back(CH_ZERO);
                        text.push_back(sel == 2 ? CH_LC_X : CH_UC_X);
                        base_of_digits = 16;
                    end
                end

                sel = $urandom_range(0, 15);
                if (sel == 0)
                    n = 0;
                else if (sel == 1)
                    n = $urandom_range(15, 30);
                else
                    n = $urandom_range(1, 8);
                repeat (n)
                    text.push_back(digit_char($urandom_range(0, base_of_digits - 1)));

                // Leave some strings open so the next start abandons them.
                if ($urandom_range(0, 9) != 0)
                    text.push_back(8'($urandom_range(0, 255)));

                if (text.size() == 0)
                    text.push_back(8'($urandom_range(0, 255)));
                send_bytes(text, r);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_sequence
        rst_n = 1'b0;
        push = 1'b0;
        start_req = 1'b0;
        ch = '0;
        radix = '0;
        clear_parse_state();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;

        test_space_and_sign();
        test_auto_base();
        test_base_range();
        test_wraparound();
        test_bad_radix_and_restart();
        test_backpressure();
        test_count_saturation();
        test_random_strings();

        wait_for_results();

        $display("Sent %0d characters and checked %0d conversions over auto, octal,",
                 chars_sent, conversions_checked);
        $display("decimal, hex and bases 2..36, with restarts, bad bases and stalls.");
        if (error_count == 0 && expected_conversions.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: several times the slowest legal run, including the saturation string.
    initial
    begin : watchdog
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
